[sv/pixel_to_ansi_ascii_art_unit_defines.svh]
// Assertion macros shared by the encoder RTL.
// Every property is clocked on clk and is switched off while rst_n is low.
`ifndef PIXEL_TO_ANSI_ASCII_ART_UNIT_DEFINES_SVH
`define PIXEL_TO_ANSI_ASCII_ART_UNIT_DEFINES_SVH

// Immediate implication: the consequent must hold in the same cycle.
`define P2A_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: the consequent must hold in the next cycle.
`define P2A_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/p2a_pkg.sv]
`timescale 1ns / 1ps

package p2a_pkg;

    // Ramp configuration.
    localparam int GLYPH_LEVELS    = 67;
    localparam int CHARS_PER_PIXEL = 20;
    localparam int RAMP_SIZE       = 67;

    // Brightness ramp, darkest first. The leftmost character sits in the top byte.
    localparam logic [8*RAMP_SIZE-1:0] GLYPH_RAMP =
        " .,'`^:;Il!i~+_-?][}{1)(|\\/tfjrxnuvczXYUJCLQ0OZmwqpdbkhao*#MW&8%B@$";

    // Fixed characters of the escape sequence.
    localparam logic [7:0] CHAR_ESC     = 8'h1B;
    localparam logic [7:0] CHAR_BRACKET = 8'h5B;
    localparam logic [7:0] CHAR_THREE   = 8'h33;
    localparam logic [7:0] CHAR_EIGHT   = 8'h38;
    localparam logic [7:0] CHAR_TWO     = 8'h32;
    localparam logic [7:0] CHAR_SEMI    = 8'h3B;
    localparam logic [7:0] CHAR_M       = 8'h6D;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;

    // Character positions within the text for one pixel.
    localparam logic [4:0] POS_ESC      = 5'd0;
    localparam logic [4:0] POS_BRACKET  = 5'd1;
    localparam logic [4:0] POS_THREE    = 5'd2;
    localparam logic [4:0] POS_EIGHT    = 5'd3;
    localparam logic [4:0] POS_SEMI_A   = 5'd4;
    localparam logic [4:0] POS_TWO      = 5'd5;
    localparam logic [4:0] POS_SEMI_B   = 5'd6;
    localparam logic [4:0] POS_RED_H    = 5'd7;
    localparam logic [4:0] POS_RED_T    = 5'd8;
    localparam logic [4:0] POS_RED_O    = 5'd9;
    localparam logic [4:0] POS_SEMI_C   = 5'd10;
    localparam logic [4:0] POS_GREEN_H  = 5'd11;
    localparam logic [4:0] POS_GREEN_T  = 5'd12;
    localparam logic [4:0] POS_GREEN_O  = 5'd13;
    localparam logic [4:0] POS_SEMI_D   = 5'd14;
    localparam logic [4:0] POS_BLUE_H   = 5'd15;
    localparam logic [4:0] POS_BLUE_T   = 5'd16;
    localparam logic [4:0] POS_BLUE_O   = 5'd17;
    localparam logic [4:0] POS_M        = 5'd18;
    localparam logic [4:0] POS_GLYPH    = 5'(CHARS_PER_PIXEL - 1);
    localparam logic [4:0] POS_NEWLINE  = 5'(CHARS_PER_PIXEL);

    // Three decimal digits of an 8-bit value.
    typedef struct packed {
        logic [3:0] hun;
        logic [3:0] ten;
        logic [3:0] one;
    } dec3_t;

    // Decimal split: compare and subtract for hundreds, reciprocal multiply for tens.
    function automatic dec3_t to_dec3(input logic [7:0] v);
        dec3_t       d;
        logic [7:0]  rem;
        logic [14:0] prod;
        logic [7:0]  tmp;
        if (v >= 8'd200)
        begin
            d.hun = 4'd2;
            rem   = v - 8'd200;
        end
        else if (v >= 8'd100)
        begin
            d.hun = 4'd1;
            rem   = v - 8'd100;
        end
        else
        begin
            d.hun = 4'd0;
            rem   = v;
        end
        // rem is below 100, where (rem * 205) >> 11 equals rem / 10.
        prod  = {7'd0, rem} * 15'd205;
        d.ten = prod[14:11];
        tmp   = rem - ({4'd0, d.ten} * 8'd10);
        d.one = tmp[3:0];
        return d;
    endfunction

    // Glyph for a luma value, saturating at the last ramp entry.
    function automatic logic [7:0] glyph_char(input logic [7:0] luma);
        logic [15:0] prod;
        logic [7:0]  idx;
        logic [6:0]  pos;
        prod = {8'd0, luma} * 16'(GLYPH_LEVELS);
        idx  = prod[15:8];
        if (idx >= 8'(RAMP_SIZE))
        begin
            idx = 8'(RAMP_SIZE - 1);
        end
        pos = 7'(RAMP_SIZE - 1) - idx[6:0];
        return GLYPH_RAMP[{pos, 3'b000} +: 8];
    endfunction

    // ASCII for a decimal digit.
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return CHAR_ZERO + {4'd0, d};
    endfunction

endpackage

[sv/pixel_to_ansi_ascii_art_unit.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// pixel     in         pixel_valid/pixel_stall red, green, blue, row_end
// text      out        text_valid/text_stall   text_byte, last
//
// Each pixel yields 20 characters, 21 at a row end, one per cycle on the text channel
// unless it stalls. The single-character output register therefore sets the pixel rate.
// An accepted pixel passes the input register and the work register before the output register.
// Reset (rst_n low, asynchronous) empties the input, work and output registers.
// A stall on the text channel holds the character sequencer; the input register
// takes one further pixel and then raises pixel_stall until the sequencer is free.
`include "pixel_to_ansi_ascii_art_unit_defines.svh"

module pixel_to_ansi_ascii_art_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pixel_valid,
    output logic       pixel_stall,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic       row_end,
    output logic       text_valid,
    input  logic       text_stall,
    output logic [7:0] text_byte,
    output logic       last
);

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_red_reg, in_green_reg, in_blue_reg;
    logic       in_row_end_reg;

    // Work register: one pixel being turned into text.
    logic          work_valid_reg, work_valid_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [7:0]    luma_reg;
    p2a_pkg::dec3_t red_dec_reg, green_dec_reg, blue_dec_reg;
    logic          work_row_end_reg;

    // Output register.
    logic       text_valid_reg, text_valid_next;
    logic [7:0] text_byte_reg;
    logic       last_reg;

    logic       pixel_accept;
    logic       advance;
    logic       final_char;
    logic       load_work;
    logic [23:0] luma_sum;
    logic [7:0]  char_sel;

    // Handshake and sequencing control.
    assign advance    = work_valid_reg && (!text_valid_reg || !text_stall);
    assign final_char = (cnt_reg == (work_row_end_reg ? p2a_pkg::POS_NEWLINE
                                                      : p2a_pkg::POS_GLYPH));
    assign load_work  = in_valid_reg && (!work_valid_reg || (advance && final_char));
    assign pixel_stall  = in_valid_reg && !load_work;
    assign pixel_accept = pixel_valid && !pixel_stall;

    // Fixed-point luma of the buffered pixel.
    assign luma_sum = (24'd19595 * {16'd0, in_red_reg})
                    + (24'd38470 * {16'd0, in_green_reg})
                    + (24'd7471  * {16'd0, in_blue_reg});

    // Character for the current position.
    always_comb
    begin
        case (cnt_reg)
            p2a_pkg::POS_ESC:     char_sel = p2a_pkg::CHAR_ESC;
            p2a_pkg::POS_BRACKET: char_sel = p2a_pkg::CHAR_BRACKET;
            p2a_pkg::POS_THREE:   char_sel = p2a_pkg::CHAR_THREE;
            p2a_pkg::POS_EIGHT:   char_sel = p2a_pkg::CHAR_EIGHT;
            p2a_pkg::POS_SEMI_A:  char_sel = p2a_pkg::CHAR_SEMI;
            p2a_pkg::POS_TWO:     char_sel = p2a_pkg::CHAR_TWO;
            p2a_pkg::POS_SEMI_B:  char_sel = p2a_pkg::CHAR_SEMI;
            p2a_pkg::POS_RED_H:   char_sel = p2a_pkg::digit_char(red_dec_reg.hun);
            p2a_pkg::POS_RED_T:   char_sel = p2a_pkg::digit_char(red_dec_reg.ten);
            p2a_pkg::POS_RED_O:   char_sel = p2a_pkg::digit_char(red_dec_reg.one);
            p2a_pkg::POS_SEMI_C:  char_sel = p2a_pkg::CHAR_SEMI;
            p2a_pkg::POS_GREEN_H: char_sel = p2a_pkg::digit_char(green_dec_reg.hun);
            p2a_pkg::POS_GREEN_T: char_sel = p2a_pkg::digit_char(green_dec_reg.ten);
            p2a_pkg::POS_GREEN_O: char_sel = p2a_pkg::digit_char(green_dec_reg.one);
            p2a_pkg::POS_SEMI_D:  char_sel = p2a_pkg::CHAR_SEMI;
            p2a_pkg::POS_BLUE_H:  char_sel = p2a_pkg::digit_char(blue_dec_reg.hun);
            p2a_pkg::POS_BLUE_T:  char_sel = p2a_pkg::digit_char(blue_dec_reg.ten);
            p2a_pkg::POS_BLUE_O:  char_sel = p2a_pkg::digit_char(blue_dec_reg.one);
            p2a_pkg::POS_M:       char_sel = p2a_pkg::CHAR_M;
            p2a_pkg::POS_GLYPH:   char_sel = p2a_pkg::glyph_char(luma_reg);
            p2a_pkg::POS_NEWLINE: char_sel = p2a_pkg::CHAR_NEWLINE;
            default:              char_sel = p2a_pkg::CHAR_NEWLINE;
        endcase
    end

    // Next-state logic for the control registers.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (pixel_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (load_work)
        begin
            in_valid_next = 1'b0;
        end

        work_valid_next = work_valid_reg;
        cnt_next        = cnt_reg;
        if (load_work)
        begin
            work_valid_next = 1'b1;
            cnt_next        = p2a_pkg::POS_ESC;
        end
        else if (advance)
        begin
            if (final_char)
            begin
                work_valid_next = 1'b0;
                cnt_next        = p2a_pkg::POS_ESC;
            end
            else
            begin
                cnt_next = cnt_reg + 5'd1;
            end
        end

        text_valid_next = text_valid_reg;
        if (advance)
        begin
            text_valid_next = 1'b1;
        end
        else if (!text_stall)
        begin
            text_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            work_valid_reg <= 1'b0;
            cnt_reg        <= p2a_pkg::POS_ESC;
            text_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            work_valid_reg <= work_valid_next;
            cnt_reg        <= cnt_next;
            text_valid_reg <= text_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            in_red_reg     <= red;
            in_green_reg   <= green;
            in_blue_reg    <= blue;
            in_row_end_reg <= row_end;
        end
        if (load_work)
        begin
            luma_reg         <= luma_sum[23:16];
            red_dec_reg      <= p2a_pkg::to_dec3(in_red_reg);
            green_dec_reg    <= p2a_pkg::to_dec3(in_green_reg);
            blue_dec_reg     <= p2a_pkg::to_dec3(in_blue_reg);
            work_row_end_reg <= in_row_end_reg;
        end
        if (advance)
        begin
            text_byte_reg <= char_sel;
            last_reg      <= final_char;
        end
    end

    assign text_valid = text_valid_reg;
    assign text_byte  = text_byte_reg;
    assign last       = last_reg;

    // Assertions.
    `P2A_ASSERT_NOW(a_cnt_range, work_valid_reg,
        cnt_reg <= (work_row_end_reg ? p2a_pkg::POS_NEWLINE : p2a_pkg::POS_GLYPH),
        "character counter beyond the end of the pixel text")
    `P2A_ASSERT_NEXT(a_last_on_final, advance && final_char,
        text_valid && last, "final character not marked last")
    `P2A_ASSERT_NEXT(a_first_is_esc, advance && (cnt_reg == p2a_pkg::POS_ESC),
        text_valid && (text_byte == p2a_pkg::CHAR_ESC) && !last,
        "pixel text does not open with escape")
    `P2A_ASSERT_NOW(a_stall_full, pixel_stall, in_valid_reg && !load_work,
        "input stalled while the input register can take a pixel")

endmodule
